// ===== rtl/core/slfo_pkg.sv =====
// slfo_pkg: shared constants, types and sine table functions for the sine lfo
// level generator; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slfo_pkg;

    localparam int PHASE_INC_W = 32;
    localparam int AMP_W       = 16;
    localparam int OFFSET_W    = 17;
    localparam int SINE_W      = 16;
    localparam int LEVEL_W     = 7;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC = 2'd0,
        CFG_AMPLITUDE = 2'd1,
        CFG_OFFSET    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                     valid;
        logic signed [SINE_W-1:0] sine;
    } t_sine_stage;

    // next taylor term magnitude before the factorial divide, q2.30
    function automatic logic [63:0] taylor_next(input logic [63:0] term,
                                                input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    function automatic logic [63:0] sub_floor(input logic [63:0] a,
                                              input logic [63:0] b);
        return (a >= b) ? a - b : 64'd0;
    endfunction

    // sin(k * (pi/2) / 2^qbits) as q1.15, used at elaboration only
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [31:0] k,
                                                       input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (64'(k) * HALF_PI_Q30) >> qbits;
        term = x;
        sum  = x;
        term = taylor_next(term, x) / 64'd6;
        sum  = sub_floor(sum, term);
        term = taylor_next(term, x) / 64'd20;
        sum  = sum + term;
        term = taylor_next(term, x) / 64'd42;
        sum  = sub_floor(sum, term);
        term = taylor_next(term, x) / 64'd72;
        sum  = sum + term;
        term = taylor_next(term, x) / 64'd110;
        sum  = sub_floor(sum, term);
        term = taylor_next(term, x) / 64'd156;
        sum  = sum + term;
        term = taylor_next(term, x) / 64'd210;
        sum  = sub_floor(sum, term);
        term = taylor_next(term, x) / 64'd272;
        sum  = sum + term;
        r = (sum + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[SINE_W-1:0];
    endfunction

    // full-wave table entry built from the quarter wave
    function automatic logic signed [SINE_W-1:0] sine_entry(input logic [31:0] idx,
                                                            input int unsigned tbits);
        int unsigned       qb;
        logic [31:0]       quad;
        logic [31:0]       rem;
        logic [31:0]       qsize;
        logic [SINE_W-1:0] v;
        qb    = tbits - 2;
        qsize = 32'd1 << qb;
        quad  = idx >> qb;
        rem   = idx & (qsize - 32'd1);
        v     = quad[0] ? quarter_sine(qsize - rem, qb) : quarter_sine(rem, qb);
        return quad[1] ? -$signed(v) : $signed(v);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slfo_phase.sv =====
// slfo_phase: phase accumulator, advanced by frame count times increment per transaction
// depends on slfo_pkg
`timescale 1ns / 1ps
`default_nettype none

module slfo_phase #(
    parameter int PHASE_BITS       = 32,
    parameter int FRAME_COUNT_BITS = 14
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_advance,
    input  wire logic [FRAME_COUNT_BITS-1:0]          i_frame_count,
    input  wire logic [slfo_pkg::PHASE_INC_W-1:0]     i_phase_inc,
    output logic      [PHASE_BITS-1:0]                o_phase
);

    localparam int PROD_W = slfo_pkg::PHASE_INC_W + FRAME_COUNT_BITS;

    logic [PROD_W-1:0]            w_prod;
    logic [PROD_W+PHASE_BITS-1:0] w_wide;
    logic [PHASE_BITS-1:0]        w_step;
    logic [PHASE_BITS-1:0]        r_phase;
    logic [PHASE_BITS-1:0]        n_phase;

    assign w_prod = PROD_W'(i_phase_inc) * PROD_W'(i_frame_count);
    // scale from units of 2^-32 of a full phase turn to units of 2^-PHASE_BITS
    assign w_wide = {w_prod, {PHASE_BITS{1'b0}}};
    assign w_step = w_wide[PHASE_BITS+31:32];

    always_comb begin
        n_phase = r_phase;
        if (i_advance) begin
            n_phase = r_phase + w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    assign o_phase = r_phase;

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_phase))
        else $error("phase moved without a transaction");

    a_phase_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_phase == '0)
        else $error("phase not cleared by reset");

endmodule

`default_nettype wire

// ===== rtl/core/slfo_sine_rom.sv =====
// slfo_sine_rom: sine table indexed by the phase, registered read into stage one
// depends on slfo_pkg
`timescale 1ns / 1ps
`default_nettype none

module slfo_sine_rom #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic                  i_move,
    input  wire logic [PHASE_BITS-1:0] i_phase,
    output slfo_pkg::t_sine_stage      o_stage
);

    localparam int ROM_DEPTH = 1 << SINE_TABLE_BITS;

    logic signed [slfo_pkg::SINE_W-1:0] w_rom [ROM_DEPTH];
    logic [SINE_TABLE_BITS-1:0]         w_idx;
    logic                               r_valid;
    logic signed [slfo_pkg::SINE_W-1:0] r_sine;

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        assign w_rom[g] = slfo_pkg::sine_entry(32'(g), SINE_TABLE_BITS);
    end

    assign w_idx = i_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_move) begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sine <= w_rom[w_idx];
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.sine  = r_sine;

endmodule

`default_nettype wire

// ===== rtl/core/slfo_level.sv =====
// slfo_level: scales the sine by amplitude, adds offset, truncates and clamps to 0..127
// output register of the block; depends on slfo_pkg
`timescale 1ns / 1ps
`default_nettype none

module slfo_level (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire slfo_pkg::t_sine_stage                 i_stage,
    input  wire logic [slfo_pkg::AMP_W-1:0]            i_amplitude,
    input  wire logic signed [slfo_pkg::OFFSET_W-1:0]  i_offset,
    input  wire logic                                  i_stall,
    output logic                                       o_ready,
    output logic                                       o_valid,
    output logic [slfo_pkg::LEVEL_W-1:0]               o_level
);

    localparam int PROD_W = slfo_pkg::AMP_W + 1 + slfo_pkg::SINE_W;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [PROD_W-1:0]           w_prod;
    logic signed [SUM_W-1:0]            w_sum;
    logic [8:0]                         w_whole;
    logic [slfo_pkg::LEVEL_W-1:0]       w_level;
    logic                               r_valid;
    logic [slfo_pkg::LEVEL_W-1:0]       r_level;

    assign w_prod  = $signed({1'b0, i_amplitude}) * i_stage.sine;
    assign w_sum   = SUM_W'($signed({i_offset, 16'd0})) + SUM_W'(w_prod);
    assign w_whole = w_sum[SUM_W-2:24];

    always_comb begin
        if (w_sum[SUM_W-1]) begin
            w_level = '0;
        end else if (w_whole > 9'(slfo_pkg::LEVEL_MAX)) begin
            w_level = slfo_pkg::LEVEL_MAX;
        end else begin
            w_level = w_whole[slfo_pkg::LEVEL_W-1:0];
        end
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_stage.valid) begin
            r_level <= w_level;
        end
    end

    assign o_valid = r_valid;
    assign o_level = r_level;

endmodule

`default_nettype wire

// ===== rtl/core/sine_lfo_level_generator.sv =====
// sine_lfo_level_generator: top level, configuration registers and pipeline control
// depends on slfo_pkg, slfo_phase, slfo_sine_rom, slfo_level
//
// usage
// - input channel: i_valid / o_stall with i_frame_count, one transaction per audio period
// - output channel: o_valid / i_stall with o_level, one transaction per input transaction
// - config: write i_cfg_data to register i_cfg_idx when i_cfg_we is high
//   (0 phase increment, 1 amplitude, 2 offset); write only while the block is idle
// - an accepted input is registered in the table stage, then in the level stage
// - throughput: one transaction per cycle while o_stall is low; the phase accumulator's
//   multiply-add is combinational and the sine table read is registered
// - the level uses the phase before the transaction's advance
// - reset clears the phase, all config registers and the valid flags of both pipeline stages
// - while i_stall holds a result, the table stage still takes one more item;
//   o_stall rises only when both stages are full and the output is stalled
`timescale 1ns / 1ps
`default_nettype none

module sine_lfo_level_generator #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_BITS  = 10,
    parameter int FRAME_COUNT_BITS = 14
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [slfo_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [slfo_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [FRAME_COUNT_BITS-1:0]           i_frame_count,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [slfo_pkg::LEVEL_W-1:0]               o_level
);

    logic [slfo_pkg::PHASE_INC_W-1:0]        r_phase_inc;
    logic [slfo_pkg::AMP_W-1:0]              r_amplitude;
    logic signed [slfo_pkg::OFFSET_W-1:0]    r_offset;
    logic [PHASE_BITS-1:0]                   w_phase;
    slfo_pkg::t_sine_stage                   w_stage;
    logic                                    w_level_ready;
    logic                                    w_move;
    logic                                    w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= '0;
            r_amplitude <= '0;
            r_offset    <= '0;
        end else if (i_cfg_we) begin
            case (slfo_pkg::t_cfg_idx'(i_cfg_idx))
                slfo_pkg::CFG_PHASE_INC: r_phase_inc <= i_cfg_data;
                slfo_pkg::CFG_AMPLITUDE: r_amplitude <= i_cfg_data[slfo_pkg::AMP_W-1:0];
                slfo_pkg::CFG_OFFSET:    r_offset    <= $signed(i_cfg_data[slfo_pkg::OFFSET_W-1:0]);
                default: ;
            endcase
        end
    end

    assign w_move   = !w_stage.valid || w_level_ready;
    assign o_stall  = !w_move;
    assign w_accept = i_valid && w_move;

    slfo_phase #(
        .PHASE_BITS       (PHASE_BITS),
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_accept),
        .i_frame_count (i_frame_count),
        .i_phase_inc   (r_phase_inc),
        .o_phase       (w_phase)
    );

    slfo_sine_rom #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_move   (w_move),
        .i_phase  (w_phase),
        .o_stage  (w_stage)
    );

    slfo_level u_level (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_stage),
        .i_amplitude (r_amplitude),
        .i_offset    (r_offset),
        .i_stall     (i_stall),
        .o_ready     (w_level_ready),
        .o_valid     (o_valid),
        .o_level     (o_level)
    );

    a_stage_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage.valid && !o_valid |=> o_valid)
        else $error("table stage item not moved to empty output");

    a_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage.valid && o_valid && i_stall |=> w_stage.valid)
        else $error("table stage item lost under stall");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_stage.valid)
        else $error("accepted transaction missing from table stage");

endmodule

`default_nettype wire
